### src/skt_pkg.sv
// Shared types and constants for the sorted unique key table.
`default_nettype none

package skt_pkg;

	localparam int unsigned CAPACITY_DEF = 64;
	localparam int unsigned KEY_W        = 32;
	localparam int unsigned POS_W        = 7;

	typedef enum logic [1:0] {
		OP_INSERT,
		OP_DELETE,
		OP_LIST_ASC,
		OP_LIST_DESC
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_DUP,
		ST_NOTFOUND,
		ST_EMPTY,
		ST_FULL
	} status_t;

	typedef struct packed {
		opcode_t                 opcode;
		logic signed [KEY_W-1:0] key;
	} req_t;

	typedef struct packed {
		status_t                 status;
		logic signed [KEY_W-1:0] entry_key;
		logic [POS_W-1:0]        position;
		logic                    last;
	} rsp_t;

	// Flags from the shared key comparator
	typedef struct packed {
		logic lt;
		logic eq;
	} cmp_t;

endpackage

`default_nettype wire

### src/sorted_unique_key_table_core.sv
// Top level: sequencer around the key store and the shared comparator.
//
// Holds up to CAPACITY unique signed keys in ascending order.
// Command channel: req (opcode, key) is transferred on a rising edge with
// start high and busy low. busy stays high until the command's last result
// has been issued. Results appear on rsp for exactly one cycle each, marked
// by rsp_valid; the receiver cannot stall them, and the last result of a
// command has rsp.last set.
// Command flow, with n keys held and p the sorted place of the key:
//   delete or list on an empty table: no walk, busy stays low and the
//   result is registered on the transfer edge.
//   insert / delete: a walk from index 0, one entry a cycle, stops at p,
//   or past the end when every key is below the new one; append, duplicate,
//   full and not found answer there. A shift then moves one entry a cycle
//   through the single store port pair. list: n results on consecutive
//   cycles, each one read from the store and then registered as a result.
// The longest command is an insert at the front of CAPACITY-1 keys: one
// comparator and one port pair, one command at a time.
// Reset empties the table at once; the store contents are not cleared.
`default_nettype none

module sorted_unique_key_table_core
	import skt_pkg::*;
#(
	parameter int unsigned CAPACITY = CAPACITY_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic busy,
	output logic rsp_valid,
	output rsp_t rsp
);

	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
	localparam logic [CW-1:0] ONE_C  = CW'(1);
	localparam logic [CW-1:0] ZERO_C = '0;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SRCH,
		S_STRM,
		S_PUT
	} state_t;

	typedef enum logic [1:0] {
		M_SHUP,
		M_SHDN,
		M_LIST
	} mode_t;

	state_t                  state_q;
	mode_t                   mode_q;
	logic                    dn_q;
	opcode_t                 op_q;
	logic signed [KEY_W-1:0] key_q;
	logic [CW-1:0]           n_q;
	logic [CW-1:0]           p_q;
	logic [CW-1:0]           r_q;
	logic [CW-1:0]           rem_q;
	logic [CW-1:0]           cnt_q;
	logic                    vld_s1;
	logic [CW-1:0]           a_s1;
	logic                    last_s1;
	rsp_t                    rsp_q;
	logic                    rsp_vld_q;

	logic                    issue;
	logic                    we;
	logic [CW-1:0]           waddr_w;
	logic signed [KEY_W-1:0] wdata;
	logic signed [KEY_W-1:0] rdata;
	cmp_t                    cmp;
	logic                    srch_hit;
	logic                    srch_exh;
	logic                    srch_end;
	logic [CW-1:0]           p_sel;
	logic                    found;

	function automatic rsp_t mk_rsp(status_t st, logic signed [KEY_W-1:0] k,
			logic [POS_W-1:0] pos, logic lst);
		rsp_t r;
		r.status    = st;
		r.entry_key = k;
		r.position  = pos;
		r.last      = lst;
		return r;
	endfunction

	skt_mem #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr_w[AW-1:0]),
		.wdata (wdata),
		.raddr (r_q[AW-1:0]),
		.rdata (rdata)
	);

	skt_cmp u_cmp (
		.a   (rdata),
		.b   (key_q),
		.res (cmp)
	);

	// One store read a cycle while a walk has entries left
	assign issue = ((state_q == S_SRCH) || (state_q == S_STRM)) && (rem_q != ZERO_C);

	// Search stops at the first entry not below the key, or past the end
	assign srch_hit = vld_s1 && !cmp.lt;
	assign srch_exh = (vld_s1 && cmp.lt && ((a_s1 + ONE_C) == n_q))
		|| (!vld_s1 && (rem_q == ZERO_C));
	assign srch_end = (state_q == S_SRCH) && (srch_hit || srch_exh);
	assign p_sel    = srch_hit ? a_s1 : n_q;
	assign found    = srch_hit && cmp.eq;

	// Store write: append at the end, shift an entry, or drop in the new key
	always_comb begin
		we      = 1'b0;
		waddr_w = p_sel;
		wdata   = key_q;
		unique case (state_q)
			S_SRCH: begin
				if (srch_end && (op_q == OP_INSERT) && !found && (n_q != CAP_C)
						&& (p_sel == n_q)) begin
					we = 1'b1;
				end
			end
			S_STRM: begin
				wdata = rdata;
				if (vld_s1 && (mode_q == M_SHUP)) begin
					we      = 1'b1;
					waddr_w = a_s1 + ONE_C;
				end else if (vld_s1 && (mode_q == M_SHDN)) begin
					we      = 1'b1;
					waddr_w = a_s1 - ONE_C;
				end
			end
			S_PUT: begin
				we      = 1'b1;
				waddr_w = p_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// Sequencer, walk pipeline and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			mode_q    <= M_LIST;
			dn_q      <= 1'b0;
			op_q      <= OP_INSERT;
			key_q     <= '0;
			n_q       <= '0;
			p_q       <= '0;
			r_q       <= '0;
			rem_q     <= '0;
			cnt_q     <= '0;
			vld_s1    <= 1'b0;
			a_s1      <= '0;
			last_s1   <= 1'b0;
			rsp_q     <= '0;
			rsp_vld_q <= 1'b0;
		end else begin
			rsp_vld_q <= 1'b0;

			// Walk pipeline: address out now, data back next cycle
			if (issue) begin
				r_q     <= dn_q ? (r_q - ONE_C) : (r_q + ONE_C);
				rem_q   <= rem_q - ONE_C;
				vld_s1  <= 1'b1;
				a_s1    <= r_q;
				last_s1 <= (rem_q == ONE_C);
			end else begin
				vld_s1 <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q   <= req.opcode;
						key_q  <= req.key;
						n_q    <= cnt_q;
						vld_s1 <= 1'b0;
						unique case (req.opcode)
							OP_INSERT, OP_DELETE: begin
								if ((req.opcode == OP_DELETE) && (cnt_q == ZERO_C)) begin
									rsp_q     <= mk_rsp(ST_EMPTY, req.key, '0, 1'b1);
									rsp_vld_q <= 1'b1;
								end else begin
									dn_q    <= 1'b0;
									r_q     <= ZERO_C;
									rem_q   <= cnt_q;
									state_q <= S_SRCH;
								end
							end
							OP_LIST_ASC, OP_LIST_DESC: begin
								if (cnt_q == ZERO_C) begin
									rsp_q     <= mk_rsp(ST_EMPTY, '0, '0, 1'b1);
									rsp_vld_q <= 1'b1;
								end else begin
									mode_q  <= M_LIST;
									dn_q    <= (req.opcode == OP_LIST_DESC);
									r_q     <= (req.opcode == OP_LIST_DESC)
										? (cnt_q - ONE_C) : ZERO_C;
									rem_q   <= cnt_q;
									state_q <= S_STRM;
								end
							end
						endcase
					end
				end

				S_SRCH: begin
					if (srch_end) begin
						p_q    <= p_sel;
						vld_s1 <= 1'b0;
						unique case (op_q)
							OP_INSERT: begin
								if (found) begin
									rsp_q     <= mk_rsp(ST_DUP, key_q, '0, 1'b1);
									rsp_vld_q <= 1'b1;
									state_q   <= S_IDLE;
								end else if (n_q == CAP_C) begin
									rsp_q     <= mk_rsp(ST_FULL, key_q, '0, 1'b1);
									rsp_vld_q <= 1'b1;
									state_q   <= S_IDLE;
								end else if (p_sel == n_q) begin
									// Largest key so far: written at the end this cycle
									cnt_q     <= cnt_q + ONE_C;
									rsp_q     <= mk_rsp(ST_OK, key_q, '0, 1'b1);
									rsp_vld_q <= 1'b1;
									state_q   <= S_IDLE;
								end else begin
									// Move entries p..n-1 up by one, top first
									mode_q  <= M_SHUP;
									dn_q    <= 1'b1;
									r_q     <= n_q - ONE_C;
									rem_q   <= n_q - p_sel;
									state_q <= S_STRM;
								end
							end
							OP_DELETE: begin
								if (!found) begin
									rsp_q     <= mk_rsp(ST_NOTFOUND, key_q, '0, 1'b1);
									rsp_vld_q <= 1'b1;
									state_q   <= S_IDLE;
								end else if ((p_sel + ONE_C) == n_q) begin
									cnt_q     <= cnt_q - ONE_C;
									rsp_q     <= mk_rsp(ST_OK, key_q, '0, 1'b1);
									rsp_vld_q <= 1'b1;
									state_q   <= S_IDLE;
								end else begin
									// Move entries p+1..n-1 down by one, bottom first
									mode_q  <= M_SHDN;
									dn_q    <= 1'b0;
									r_q     <= p_sel + ONE_C;
									rem_q   <= n_q - p_sel - ONE_C;
									state_q <= S_STRM;
								end
							end
							OP_LIST_ASC, OP_LIST_DESC: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end

				S_STRM: begin
					if (vld_s1) begin
						unique case (mode_q)
							M_SHUP: begin
								if (last_s1) begin
									state_q <= S_PUT;
								end
							end
							M_SHDN: begin
								if (last_s1) begin
									cnt_q     <= cnt_q - ONE_C;
									rsp_q     <= mk_rsp(ST_OK, key_q, '0, 1'b1);
									rsp_vld_q <= 1'b1;
									state_q   <= S_IDLE;
								end
							end
							M_LIST: begin
								rsp_q     <= mk_rsp(ST_OK, rdata, POS_W'(a_s1 + ONE_C),
									last_s1);
								rsp_vld_q <= 1'b1;
								if (last_s1) begin
									state_q <= S_IDLE;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end

				S_PUT: begin
					cnt_q     <= cnt_q + ONE_C;
					rsp_q     <= mk_rsp(ST_OK, key_q, '0, 1'b1);
					rsp_vld_q <= 1'b1;
					state_q   <= S_IDLE;
				end
			endcase
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign rsp_valid = rsp_vld_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

### src/skt_mem.sv
// Key store: one write port, one read port with registered read data.
`default_nettype none

module skt_mem
	import skt_pkg::*;
#(
	parameter int unsigned DEPTH = CAPACITY_DEF,
	parameter int unsigned AW    = 6
) (
	input  logic                    clk,
	input  logic                    we,
	input  logic [AW-1:0]           waddr,
	input  logic signed [KEY_W-1:0] wdata,
	input  logic [AW-1:0]           raddr,
	output logic signed [KEY_W-1:0] rdata
);

	logic signed [KEY_W-1:0] store_q [DEPTH];
	logic signed [KEY_W-1:0] rdata_q;

	// Contents are undefined until written; no reset
	always_ff @(posedge clk) begin
		if (we) begin
			store_q[waddr] <= wdata;
		end
		rdata_q <= store_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### src/skt_cmp.sv
// Shared signed key comparator used by the search walk.
`default_nettype none

module skt_cmp
	import skt_pkg::*;
(
	input  logic signed [KEY_W-1:0] a,
	input  logic signed [KEY_W-1:0] b,
	output cmp_t                    res
);

	// Both operands signed, so this is a two's complement compare
	assign res.lt = (a < b);
	assign res.eq = (a == b);

endmodule

`default_nettype wire

### src/skt_chk.sv
// Port-level checks for the sorted unique key table, bound to the top level.
`default_nettype none

module skt_chk
	import skt_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input req_t req,
	input logic busy,
	input logic rsp_valid,
	input rsp_t rsp
);

	// A listing streams without gaps until its last result
	a_list_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.last |=> rsp_valid)
		else $error("listing stream broke before its last result");

	// Only listed entries come without last, and they are always ok
	a_nonlast_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.last |-> (rsp.status == ST_OK) && (rsp.position != '0))
		else $error("non-final result is not a listed entry");

	// A rank is only given with status ok
	a_pos_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.position != '0) |-> (rsp.status == ST_OK))
		else $error("rank given with an error status");

	// No result without a command in progress or just transferred
	a_rsp_caused: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> $past(busy) || $past(start))
		else $error("result with no command behind it");

endmodule

bind sorted_unique_key_table_core skt_chk u_skt_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.req       (req),
	.busy      (busy),
	.rsp_valid (rsp_valid),
	.rsp       (rsp)
);

`default_nettype wire

### tb/sv/tb_sorted_unique_key_table_core.sv
// Self-checking testbench for the sorted unique key table core.
`default_nettype none

module tb_sorted_unique_key_table_core;
	import skt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned TABLE_DEPTH = CAPACITY_DEF;
	localparam int          CYCLE_LIMIT = 400000;
	localparam int          ITEM_TARGET = 480;

	// Predicts the table's answers and holds the ones still owed
	class key_table_scoreboard;
		logic signed [KEY_W-1:0] stored [TABLE_DEPTH];
		int unsigned             held;
		rsp_t                    owed_answers [$];
		int                      mismatches;

		function new();
			held       = 0;
			mismatches = 0;
		endfunction

		function void owe(status_t st, logic signed [KEY_W-1:0] k, int unsigned pos, bit fin);
			rsp_t a;
			a.status    = st;
			a.entry_key = k;
			a.position  = POS_W'(pos);
			a.last      = fin;
			owed_answers.push_back(a);
		endfunction

		// Works out the answers to one transferred command and updates the table copy
		function void predict_command(req_t r);
			int unsigned p;
			int unsigned i;
			int unsigned idx;
			p = 0;
			while (p < held && $signed(stored[p]) < $signed(r.key))
				p++;
			case (r.opcode)
				OP_INSERT: begin
					if (p < held && stored[p] == r.key) begin
						owe(ST_DUP, r.key, 0, 1'b1);
					end else if (held >= TABLE_DEPTH) begin
						owe(ST_FULL, r.key, 0, 1'b1);
					end else begin
						for (i = held; i > p; i--)
							stored[i] = stored[i - 1];
						stored[p] = r.key;
						held++;
						owe(ST_OK, r.key, 0, 1'b1);
					end
				end
				OP_DELETE: begin
					if (held == 0) begin
						owe(ST_EMPTY, r.key, 0, 1'b1);
					end else if (p >= held || stored[p] != r.key) begin
						owe(ST_NOTFOUND, r.key, 0, 1'b1);
					end else begin
						for (i = p; i + 1 < held; i++)
							stored[i] = stored[i + 1];
						held--;
						owe(ST_OK, r.key, 0, 1'b1);
					end
				end
				default: begin
					if (held == 0) begin
						owe(ST_EMPTY, '0, 0, 1'b1);
					end else begin
						for (i = 0; i < held; i++) begin
							idx = (r.opcode == OP_LIST_ASC) ? i : held - 1 - i;
							owe(ST_OK, stored[idx], idx + 1, i + 1 == held);
						end
					end
				end
			endcase
		endfunction

		task report_mismatch(string what);
			$display("mismatch at %0t: %s", $realtime, what);
			mismatches++;
		endtask

		// Compares one result transfer with the oldest answer owed
		task check_answer(rsp_t got);
			rsp_t want;
			if (owed_answers.size() == 0) begin
				report_mismatch($sformatf("unexpected result %p", got));
			end else begin
				want = owed_answers.pop_front();
				if (got.status !== want.status)
					report_mismatch($sformatf("status %0d, want %0d",
						got.status, want.status));
				if (got.entry_key !== want.entry_key)
					report_mismatch($sformatf("entry_key %0d, want %0d",
						got.entry_key, want.entry_key));
				if (got.position !== want.position)
					report_mismatch($sformatf("position %0d, want %0d",
						got.position, want.position));
				if (got.last !== want.last)
					report_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic start;
	req_t req;
	logic busy;
	logic rsp_valid;
	rsp_t rsp;

	key_table_scoreboard sb = new();
	int                  cycle_count = 0;
	int                  items_sent = 0;

	sorted_unique_key_table_core #(
		.CAPACITY(TABLE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req(req),
		.busy(busy),
		.rsp_valid(rsp_valid),
		.rsp(rsp)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Result transfers are checked on the edge that ends them
	always @(posedge clk) begin
		if (arst_n && rsp_valid)
			sb.check_answer(rsp);
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("sorted_unique_key_table_core regression: fail");
			$finish;
		end
	end

	// Mostly short pauses, now and then a long one
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 4);
		return $urandom_range(12, 40);
	endfunction

	// Full-range keys half the time, otherwise a narrow band so that neighbours and repeats occur
	function automatic logic signed [KEY_W-1:0] fresh_key();
		if ($urandom_range(0, 1))
			return $urandom;
		return $signed($urandom_range(0, 64)) - 32;
	endfunction

	function automatic logic signed [KEY_W-1:0] held_key();
		if (sb.held == 0)
			return fresh_key();
		return sb.stored[$urandom_range(0, sb.held - 1)];
	endfunction

	function automatic opcode_t list_dir();
		return $urandom_range(0, 1) ? OP_LIST_ASC : OP_LIST_DESC;
	endfunction

	// One command transfer, then an optional pause with start low
	task automatic issue(input opcode_t op, input logic signed [KEY_W-1:0] k);
		req_t r;
		int   gap;
		r.opcode = op;
		r.key    = k;
		start <= 1'b1;
		req   <= r;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		sb.predict_command(r);
		items_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Build the table up until it is full, then probe it while full
	task automatic fill_table();
		int roll;
		int n;
		while (sb.held < TABLE_DEPTH) begin
			roll = $urandom_range(0, 99);
			if (roll < 66)
				issue(OP_INSERT, fresh_key());
			else if (roll < 80)
				issue(OP_INSERT, held_key());
			else if (roll < 88)
				issue(OP_DELETE, $urandom_range(0, 1) ? held_key() : fresh_key());
			else
				issue(list_dir(), $urandom);
		end
		issue(OP_LIST_ASC, $urandom);
		issue(OP_LIST_DESC, $urandom);
		for (n = 0; n < 6; n++)
			issue(OP_INSERT, n[0] ? held_key() : fresh_key());
	endtask

	// Take the table down to empty, then poke the empty table
	task automatic drain_table();
		int roll;
		while (sb.held > 0) begin
			roll = $urandom_range(0, 99);
			if (roll < 75)
				issue(OP_DELETE, held_key());
			else if (roll < 85)
				issue(OP_DELETE, fresh_key());
			else if (roll < 93)
				issue(OP_INSERT, fresh_key());
			else
				issue(list_dir(), $urandom);
		end
		issue(OP_DELETE, fresh_key());
		issue(OP_DELETE, $urandom);
		issue(list_dir(), $urandom);
	endtask

	initial begin
		int roll;
		clk    = 1'b0;
		arst_n <= 1'b0;
		start  <= 1'b0;
		req    <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, extremes, duplicates, absent keys, both listings
		issue(OP_LIST_ASC, 32'sd0);
		issue(OP_LIST_DESC, -32'sd1);
		issue(OP_DELETE, 32'sd5);
		issue(OP_INSERT, 32'sh7FFF_FFFF);
		issue(OP_INSERT, 32'sh8000_0000);
		issue(OP_INSERT, 32'sd0);
		issue(OP_INSERT, -32'sd1);
		issue(OP_INSERT, 32'sd1);
		issue(OP_INSERT, 32'sd0);
		issue(OP_INSERT, 32'sh8000_0000);
		issue(OP_DELETE, 32'sd7);
		issue(OP_LIST_ASC, 32'sh5555_5555);
		issue(OP_LIST_DESC, 32'shAAAA_AAAA);
		issue(OP_DELETE, 32'sh8000_0000);
		issue(OP_DELETE, 32'sh7FFF_FFFF);
		issue(OP_DELETE, 32'sd0);
		issue(OP_LIST_DESC, 32'sd0);
		issue(OP_DELETE, -32'sd1);
		issue(OP_DELETE, 32'sd1);
		issue(OP_DELETE, 32'sd1);
		issue(OP_LIST_ASC, -32'sd1);

		// Random: two full fill and drain rounds, then a free mix
		repeat (2) begin
			fill_table();
			drain_table();
		end
		while (items_sent < ITEM_TARGET) begin
			roll = $urandom_range(0, 99);
			if (roll < 40)
				issue(OP_INSERT, $urandom_range(0, 3) ? fresh_key() : held_key());
			else if (roll < 75)
				issue(OP_DELETE, $urandom_range(0, 1) ? held_key() : fresh_key());
			else
				issue(list_dir(), $urandom);
		end
		start <= 1'b0;

		// Let every owed answer arrive, then watch for strays
		while (sb.owed_answers.size() != 0)
			@(posedge clk);
		repeat (TABLE_DEPTH + 16) @(posedge clk);

		if (sb.mismatches == 0)
			$display("sorted_unique_key_table_core regression: pass");
		else
			$display("sorted_unique_key_table_core regression: fail");
		$finish;
	end

endmodule

`default_nettype wire
